[hdl/srlc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlc_pkg
// Types, codes and helpers shared by the selective repeat link controller.
// ----------------------------------------------------------------------------
package srlc_pkg;

    localparam int SEQ_BITS  = 5;
    localparam int SLOT_BITS = SEQ_BITS - 1;
    localparam int NR_BUFS   = 1 << SLOT_BITS;
    localparam int CNT_BITS  = SLOT_BITS + 1;

    localparam logic [15:0] DATA_TIMER_RESET = 16'd1200;
    localparam logic [15:0] ACK_TIMER_RESET  = 16'd110;
    localparam logic [9:0]  MIN_CRC_LENGTH   = 10'd7;
    localparam logic [9:0]  SHORT_CTRL_LEN   = 10'd2;

    localparam logic [2:0] KIND_HOST     = 3'd0;
    localparam logic [2:0] KIND_LINK     = 3'd1;
    localparam logic [2:0] KIND_FRAME    = 3'd2;
    localparam logic [2:0] KIND_DATA_TO  = 3'd3;
    localparam logic [2:0] KIND_ACK_TO   = 3'd4;

    localparam logic [1:0] FTYPE_DATA = 2'd0;
    localparam logic [1:0] FTYPE_ACK  = 2'd1;
    localparam logic [1:0] FTYPE_NAK  = 2'd2;

    localparam logic [3:0] ACT_STATUS   = 4'd0;
    localparam logic [3:0] ACT_SEND     = 4'd1;
    localparam logic [3:0] ACT_ACK      = 4'd2;
    localparam logic [3:0] ACT_NAK      = 4'd3;
    localparam logic [3:0] ACT_DELIVER  = 4'd4;
    localparam logic [3:0] ACT_START_DT = 4'd5;
    localparam logic [3:0] ACT_STOP_DT  = 4'd6;
    localparam logic [3:0] ACT_START_AT = 4'd7;
    localparam logic [3:0] ACT_STOP_AT  = 4'd8;
    localparam logic [3:0] ACT_STORE    = 4'd9;

    localparam logic CFG_DATA_TIMER = 1'b0;
    localparam logic CFG_ACK_TIMER  = 1'b1;

    typedef struct packed {
        logic [2:0]           kind;
        logic [9:0]           rx_length;
        logic                 rx_crc_ok;
        logic [1:0]           rx_frame_type;
        logic [SEQ_BITS-1:0]  rx_seq_number;
        logic [SEQ_BITS-1:0]  rx_ack_number;
        logic [SLOT_BITS-1:0] timeout_slot;
    } in_item_t;

    typedef struct packed {
        logic [3:0]           action;
        logic [SEQ_BITS-1:0]  tx_seq_number;
        logic [SEQ_BITS-1:0]  tx_ack_number;
        logic [SLOT_BITS-1:0] buffer_slot;
        logic [15:0]          timer_length;
        logic                 network_enable;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [3:0] action;
        logic       set_link;
        logic       clr_link;
        logic       inc_out;
        logic       inc_nss;
        logic       clr_nak;
        logic       set_arrived;
        logic       deliver_step;
        logic       ack_step;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] frame_type;
        logic       bad;
        logic       seq_ne_exp;
        logic       nak_allowed;
        logic       full;
        logic       rx_accept;
        logic       arrived_exp;
        logic       want_in_win;
        logic       ack_in_win;
        logic       out_free;
    } stat_t;

    // True when b lies in the circular window [a, c).
    function automatic logic in_window(input logic [SEQ_BITS-1:0] a,
                                       input logic [SEQ_BITS-1:0] b,
                                       input logic [SEQ_BITS-1:0] c);
        in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                    ((b < c) && (c < a));
    endfunction

endpackage

[hdl/srlc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlc_ctrl
// Sequencer that walks one event through its list of commands.
// ----------------------------------------------------------------------------
module srlc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire srlc_pkg::stat_t stat,
    output srlc_pkg::cmd_t       cmd
);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_DECODE     = 4'd1;
    localparam logic [3:0] ST_STORE      = 4'd2;
    localparam logic [3:0] ST_DATA       = 4'd3;
    localparam logic [3:0] ST_START_DT   = 4'd4;
    localparam logic [3:0] ST_STOP_AT    = 4'd5;
    localparam logic [3:0] ST_NAK        = 4'd6;
    localparam logic [3:0] ST_ACK        = 4'd7;
    localparam logic [3:0] ST_START_AT   = 4'd8;
    localparam logic [3:0] ST_MARK       = 4'd9;
    localparam logic [3:0] ST_DLOOP      = 4'd10;
    localparam logic [3:0] ST_DELIVER    = 4'd11;
    localparam logic [3:0] ST_DELIVER_AT = 4'd12;
    localparam logic [3:0] ST_ACKLOOP    = 4'd13;
    localparam logic [3:0] ST_STATUS     = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        if (state_reg == ST_IDLE)
        begin
            if (in_valid)
            begin
                cmd.load   = 1'b1;
                state_next = ST_DECODE;
            end
        end
        else if (stat.out_free)
        begin
            case (state_reg)
                ST_DECODE:
                begin
                    case (stat.kind)
                        srlc_pkg::KIND_HOST:
                            state_next = stat.full ? ST_STATUS : ST_STORE;
                        srlc_pkg::KIND_LINK:
                        begin
                            cmd.set_link = 1'b1;
                            state_next   = ST_STATUS;
                        end
                        srlc_pkg::KIND_FRAME:
                        begin
                            if (stat.bad)
                                state_next = stat.nak_allowed ? ST_NAK : ST_STATUS;
                            else if (stat.frame_type == srlc_pkg::FTYPE_DATA)
                                state_next = (stat.seq_ne_exp && stat.nak_allowed) ?
                                             ST_NAK : ST_START_AT;
                            else if (stat.frame_type == srlc_pkg::FTYPE_NAK)
                                state_next = stat.want_in_win ? ST_DATA : ST_ACKLOOP;
                            else
                                state_next = ST_ACKLOOP;
                        end
                        srlc_pkg::KIND_DATA_TO: state_next = ST_DATA;
                        srlc_pkg::KIND_ACK_TO:  state_next = ST_ACK;
                        default:                state_next = ST_STATUS;
                    endcase
                end
                ST_STORE:
                begin
                    cmd.emit    = 1'b1;
                    cmd.action  = srlc_pkg::ACT_STORE;
                    cmd.inc_out = 1'b1;
                    state_next  = ST_DATA;
                end
                ST_DATA:
                begin
                    cmd.emit     = 1'b1;
                    cmd.action   = srlc_pkg::ACT_SEND;
                    cmd.clr_link = 1'b1;
                    state_next   = ST_START_DT;
                end
                ST_START_DT:
                begin
                    cmd.emit   = 1'b1;
                    cmd.action = srlc_pkg::ACT_START_DT;
                    state_next = ST_STOP_AT;
                end
                ST_NAK:
                begin
                    cmd.emit    = 1'b1;
                    cmd.action  = srlc_pkg::ACT_NAK;
                    cmd.clr_nak = 1'b1;
                    state_next  = ST_STOP_AT;
                end
                ST_ACK:
                begin
                    cmd.emit   = 1'b1;
                    cmd.action = srlc_pkg::ACT_ACK;
                    state_next = ST_STOP_AT;
                end
                ST_STOP_AT:
                begin
                    cmd.emit   = 1'b1;
                    cmd.action = srlc_pkg::ACT_STOP_AT;
                    // The host packet's sequence number advances once its send is done.
                    cmd.inc_nss = (stat.kind == srlc_pkg::KIND_HOST);
                    if ((stat.kind == srlc_pkg::KIND_FRAME) && !stat.bad)
                        state_next = (stat.frame_type == srlc_pkg::FTYPE_DATA) ?
                                     ST_MARK : ST_ACKLOOP;
                    else
                        state_next = ST_STATUS;
                end
                ST_START_AT:
                begin
                    cmd.emit   = 1'b1;
                    cmd.action = srlc_pkg::ACT_START_AT;
                    state_next = ST_MARK;
                end
                ST_MARK:
                begin
                    cmd.set_arrived = stat.rx_accept;
                    state_next      = stat.rx_accept ? ST_DLOOP : ST_ACKLOOP;
                end
                ST_DLOOP:
                    state_next = stat.arrived_exp ? ST_DELIVER : ST_ACKLOOP;
                ST_DELIVER:
                begin
                    cmd.emit         = 1'b1;
                    cmd.action       = srlc_pkg::ACT_DELIVER;
                    cmd.deliver_step = 1'b1;
                    state_next       = ST_DELIVER_AT;
                end
                ST_DELIVER_AT:
                begin
                    cmd.emit   = 1'b1;
                    cmd.action = srlc_pkg::ACT_START_AT;
                    state_next = ST_DLOOP;
                end
                ST_ACKLOOP:
                begin
                    if (stat.ack_in_win)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.action   = srlc_pkg::ACT_STOP_DT;
                        cmd.ack_step = 1'b1;
                    end
                    else
                        state_next = ST_STATUS;
                end
                ST_STATUS:
                begin
                    cmd.emit   = 1'b1;
                    cmd.action = srlc_pkg::ACT_STATUS;
                    state_next = ST_IDLE;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("command issued while the result register is occupied");
    a_status_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.action == srlc_pkg::ACT_STATUS) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after status");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DECODE))
        else $error("event load did not start decode");
`endif

endmodule
`default_nettype wire

[hdl/srlc_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlc_dpath
// Window state, configuration registers and the result register.
// ----------------------------------------------------------------------------
module srlc_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire srlc_pkg::in_item_t in_data,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output srlc_pkg::out_item_t     out_data,
    input  wire logic               cfg_write_en,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire srlc_pkg::cmd_t     cmd,
    output srlc_pkg::stat_t         stat
);

    localparam int SB = srlc_pkg::SEQ_BITS;
    localparam int LB = srlc_pkg::SLOT_BITS;
    localparam int CB = srlc_pkg::CNT_BITS;

    srlc_pkg::in_item_t  ev_reg;
    srlc_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [15:0]         dtl_reg, atl_reg;
    logic [SB-1:0]       nss_reg, nss_next;
    logic [SB-1:0]       old_reg, old_next;
    logic [SB-1:0]       exp_reg, exp_next;
    logic [SB-1:0]       rwe_reg, rwe_next;
    logic [CB-1:0]       cnt_reg, cnt_next;
    logic [srlc_pkg::NR_BUFS-1:0] arr_reg, arr_next;
    logic                nak_reg, nak_next;
    logic                link_reg, link_next;

    logic [SB-1:0]       piggy;
    logic [SB-1:0]       want;
    logic [SB-1:0]       tmo_seq;
    logic [SB-1:0]       send_seq;
    logic [LB-1:0]       tmo_slot;

    assign piggy    = exp_reg - SB'(1);
    assign want     = ev_reg.rx_ack_number + SB'(1);
    assign tmo_slot = ev_reg.timeout_slot;
    assign tmo_seq  = srlc_pkg::in_window(old_reg, {1'b0, tmo_slot}, nss_reg) ?
                      {1'b0, tmo_slot} : {1'b1, tmo_slot};

    always_comb
    begin
        case (ev_reg.kind)
            srlc_pkg::KIND_HOST:    send_seq = nss_reg;
            srlc_pkg::KIND_DATA_TO: send_seq = tmo_seq;
            default:                send_seq = want;
        endcase
    end

    always_comb
    begin
        stat.kind        = ev_reg.kind;
        stat.frame_type  = ev_reg.rx_frame_type;
        stat.bad         = ((ev_reg.rx_length < srlc_pkg::MIN_CRC_LENGTH) &&
                            (ev_reg.rx_length != srlc_pkg::SHORT_CTRL_LEN)) ||
                           ((ev_reg.rx_length >= srlc_pkg::MIN_CRC_LENGTH) &&
                            !ev_reg.rx_crc_ok);
        stat.seq_ne_exp  = (ev_reg.rx_seq_number != exp_reg);
        stat.nak_allowed = nak_reg;
        stat.full        = (cnt_reg >= CB'(srlc_pkg::NR_BUFS));
        stat.rx_accept   = srlc_pkg::in_window(exp_reg, ev_reg.rx_seq_number, rwe_reg) &&
                           !arr_reg[ev_reg.rx_seq_number[LB-1:0]];
        stat.arrived_exp = arr_reg[exp_reg[LB-1:0]];
        stat.want_in_win = srlc_pkg::in_window(old_reg, want, nss_reg);
        stat.ack_in_win  = srlc_pkg::in_window(old_reg, ev_reg.rx_ack_number, nss_reg);
        stat.out_free    = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        nss_next       = nss_reg;
        old_next       = old_reg;
        exp_next       = exp_reg;
        rwe_next       = rwe_reg;
        cnt_next       = cnt_reg;
        arr_next       = arr_reg;
        nak_next       = nak_reg;
        link_next      = link_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.set_link)
            link_next = 1'b1;
        if (cmd.clr_link)
            link_next = 1'b0;
        if (cmd.inc_out)
            cnt_next = cnt_reg + CB'(1);
        if (cmd.inc_nss)
            nss_next = nss_reg + SB'(1);
        if (cmd.clr_nak)
            nak_next = 1'b0;
        if (cmd.set_arrived)
            arr_next[ev_reg.rx_seq_number[LB-1:0]] = 1'b1;
        if (cmd.deliver_step)
        begin
            arr_next[exp_reg[LB-1:0]] = 1'b0;
            exp_next = exp_reg + SB'(1);
            rwe_next = rwe_reg + SB'(1);
            nak_next = 1'b1;
        end
        if (cmd.ack_step)
        begin
            old_next = old_reg + SB'(1);
            if (cnt_reg != '0)
                cnt_next = cnt_reg - CB'(1);
        end

        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_next        = '0;
            out_next.action = cmd.action;
            case (cmd.action)
                srlc_pkg::ACT_STORE:
                    out_next.buffer_slot = nss_reg[LB-1:0];
                srlc_pkg::ACT_SEND:
                begin
                    out_next.tx_seq_number = send_seq;
                    out_next.tx_ack_number = piggy;
                    out_next.buffer_slot   = send_seq[LB-1:0];
                end
                srlc_pkg::ACT_START_DT:
                begin
                    out_next.buffer_slot  = send_seq[LB-1:0];
                    out_next.timer_length = dtl_reg;
                end
                srlc_pkg::ACT_ACK, srlc_pkg::ACT_NAK:
                    out_next.tx_ack_number = piggy;
                srlc_pkg::ACT_START_AT:
                    out_next.timer_length = atl_reg;
                srlc_pkg::ACT_DELIVER:
                    out_next.buffer_slot = exp_reg[LB-1:0];
                srlc_pkg::ACT_STOP_DT:
                    out_next.buffer_slot = old_reg[LB-1:0];
                srlc_pkg::ACT_STATUS:
                begin
                    out_next.network_enable = (cnt_reg < CB'(srlc_pkg::NR_BUFS)) && link_reg;
                    out_next.last           = 1'b1;
                end
                default: out_next.action = cmd.action;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dtl_reg       <= srlc_pkg::DATA_TIMER_RESET;
            atl_reg       <= srlc_pkg::ACK_TIMER_RESET;
            nss_reg       <= '0;
            old_reg       <= '0;
            exp_reg       <= '0;
            rwe_reg       <= SB'(srlc_pkg::NR_BUFS);
            cnt_reg       <= '0;
            arr_reg       <= '0;
            nak_reg       <= 1'b1;
            link_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en && (cfg_index == srlc_pkg::CFG_DATA_TIMER))
                dtl_reg <= cfg_data;
            if (cfg_write_en && (cfg_index == srlc_pkg::CFG_ACK_TIMER))
                atl_reg <= cfg_data;
            nss_reg       <= nss_next;
            old_reg       <= old_next;
            exp_reg       <= exp_next;
            rwe_reg       <= rwe_next;
            cnt_reg       <= cnt_next;
            arr_reg       <= arr_next;
            nak_reg       <= nak_next;
            link_reg      <= link_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.load)
            ev_reg <= in_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CB'(srlc_pkg::NR_BUFS))
        else $error("outstanding count above window size");
    a_rx_window_span: assert property (@(posedge clk) disable iff (!rst_n)
        (rwe_reg - exp_reg) == SB'(srlc_pkg::NR_BUFS))
        else $error("receive window lost its width");
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last == (out_reg.action == srlc_pkg::ACT_STATUS)))
        else $error("last flag not on the status result");
`endif

endmodule
`default_nettype wire

[hdl/selective_repeat_link_controller_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_link_controller_core
// Selective repeat ARQ window controller: turns link events into commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  srlc_pkg::in_item_t (one event)
// out       output     out_valid/out_stall srlc_pkg::out_item_t (one command)
// cfg       input      cfg_write_en       cfg_index, cfg_data (timer lengths)
//
// An event is loaded and decoded, then its results are transferred one by one;
// a received data frame is also marked, each delivery is checked, and the
// acknowledgement scan of every good frame is closed.
// Reset clears the window state and loads the default timer lengths.
// A stall on the output holds the sequencer; no new event is taken until the
// status result of the current one has been issued.
// ----------------------------------------------------------------------------
module selective_repeat_link_controller_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire srlc_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output srlc_pkg::out_item_t      out_data,
    input  wire logic                cfg_write_en,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data
);

    srlc_pkg::cmd_t  cmd;
    srlc_pkg::stat_t stat;

    srlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    srlc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (in_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective repeat link controller testbench
// Drives link events into the controller and checks every command it issues
// against a cycle-free model of the ARQ window held in the testbench. Runs a
// short directed table, then random traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;
    localparam int SB             = srlc_pkg::SEQ_BITS;
    localparam int LB             = srlc_pkg::SLOT_BITS;
    localparam int IN_BITS        = $bits(srlc_pkg::in_item_t);

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    srlc_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    srlc_pkg::out_item_t out_data;
    logic                cfg_write_en;
    logic                cfg_index;
    logic [15:0]         cfg_data;

    selective_repeat_link_controller_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Window state mirrored by the predictor.
    logic [15:0]          m_data_tlen;
    logic [15:0]          m_ack_tlen;
    logic [SB-1:0]        m_next_send;
    logic [SB-1:0]        m_oldest;
    logic [SB-1:0]        m_expected;
    logic [SB-1:0]        m_win_end;
    int                   m_outstanding;
    logic [srlc_pkg::NR_BUFS-1:0] m_arrived;
    logic                 m_nak_ok;
    logic                 m_link;

    srlc_pkg::out_item_t expected_cmds[$];
    int                  mismatches;
    int                  reports;
    int                  idle_pct;
    int                  stall_pct;
    bit                  hold_off;
    bit                  timed_out;
    int                  quiet_cycles;

    function automatic logic win_has(input logic [SB-1:0] a,
                                     input logic [SB-1:0] b,
                                     input logic [SB-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    task automatic push_cmd(input logic [3:0] act, input logic [SB-1:0] seq,
                            input logic [SB-1:0] ack,
                            input logic [LB-1:0] slot,
                            input logic [15:0] tlen, input logic ne,
                            input logic lst);
        srlc_pkg::out_item_t c;
        c.action         = act;
        c.tx_seq_number  = seq;
        c.tx_ack_number  = ack;
        c.buffer_slot    = slot;
        c.timer_length   = tlen;
        c.network_enable = ne;
        c.last           = lst;
        expected_cmds.push_back(c);
    endtask

    task automatic model_send_data(input logic [SB-1:0] seq);
        push_cmd(srlc_pkg::ACT_SEND, seq, m_expected - 1'b1, seq[LB-1:0], 16'd0,
                 1'b0, 1'b0);
        m_link = 1'b0;
        push_cmd(srlc_pkg::ACT_START_DT, '0, '0, seq[LB-1:0], m_data_tlen, 1'b0, 1'b0);
        push_cmd(srlc_pkg::ACT_STOP_AT, '0, '0, '0, 16'd0, 1'b0, 1'b0);
    endtask

    task automatic model_send_nak();
        push_cmd(srlc_pkg::ACT_NAK, '0, m_expected - 1'b1, '0, 16'd0, 1'b0, 1'b0);
        m_nak_ok = 1'b0;
        push_cmd(srlc_pkg::ACT_STOP_AT, '0, '0, '0, 16'd0, 1'b0, 1'b0);
    endtask

    task automatic model_frame(input srlc_pkg::in_item_t ev);
        logic [SB-1:0] want;
        if ((ev.rx_length < srlc_pkg::MIN_CRC_LENGTH &&
             ev.rx_length != srlc_pkg::SHORT_CTRL_LEN) ||
            (ev.rx_length >= srlc_pkg::MIN_CRC_LENGTH && !ev.rx_crc_ok))
        begin
            if (m_nak_ok)
                model_send_nak();
            return;
        end
        if (ev.rx_frame_type == srlc_pkg::FTYPE_DATA)
        begin
            if (ev.rx_seq_number != m_expected && m_nak_ok)
                model_send_nak();
            else
                push_cmd(srlc_pkg::ACT_START_AT, '0, '0, '0, m_ack_tlen, 1'b0, 1'b0);
            if (win_has(m_expected, ev.rx_seq_number, m_win_end) &&
                !m_arrived[ev.rx_seq_number[LB-1:0]])
            begin
                m_arrived[ev.rx_seq_number[LB-1:0]] = 1'b1;
                while (m_arrived[m_expected[LB-1:0]])
                begin
                    push_cmd(srlc_pkg::ACT_DELIVER, '0, '0, m_expected[LB-1:0], 16'd0,
                             1'b0, 1'b0);
                    m_arrived[m_expected[LB-1:0]] = 1'b0;
                    m_expected = m_expected + 1'b1;
                    m_win_end  = m_win_end + 1'b1;
                    m_nak_ok   = 1'b1;
                    push_cmd(srlc_pkg::ACT_START_AT, '0, '0, '0, m_ack_tlen, 1'b0, 1'b0);
                end
            end
        end
        if (ev.rx_frame_type == srlc_pkg::FTYPE_NAK)
        begin
            want = ev.rx_ack_number + 1'b1;
            if (win_has(m_oldest, want, m_next_send))
                model_send_data(want);
        end
        while (win_has(m_oldest, ev.rx_ack_number, m_next_send))
        begin
            push_cmd(srlc_pkg::ACT_STOP_DT, '0, '0, m_oldest[LB-1:0], 16'd0, 1'b0, 1'b0);
            m_oldest = m_oldest + 1'b1;
            if (m_outstanding > 0)
                m_outstanding--;
        end
    endtask

    task automatic predict_event(input srlc_pkg::in_item_t ev);
        logic [SB-1:0] s;
        case (ev.kind)
            srlc_pkg::KIND_HOST:
                if (m_outstanding < srlc_pkg::NR_BUFS)
                begin
                    push_cmd(srlc_pkg::ACT_STORE, '0, '0, m_next_send[LB-1:0], 16'd0,
                             1'b0, 1'b0);
                    m_outstanding++;
                    model_send_data(m_next_send);
                    m_next_send = m_next_send + 1'b1;
                end
            srlc_pkg::KIND_LINK:    m_link = 1'b1;
            srlc_pkg::KIND_FRAME:   model_frame(ev);
            srlc_pkg::KIND_DATA_TO:
            begin
                s = {1'b0, ev.timeout_slot};
                if (!win_has(m_oldest, s, m_next_send))
                    s = {1'b1, ev.timeout_slot};
                model_send_data(s);
            end
            srlc_pkg::KIND_ACK_TO:
            begin
                push_cmd(srlc_pkg::ACT_ACK, '0, m_expected - 1'b1, '0, 16'd0, 1'b0, 1'b0);
                push_cmd(srlc_pkg::ACT_STOP_AT, '0, '0, '0, 16'd0, 1'b0, 1'b0);
            end
            default: ;
        endcase
        push_cmd(srlc_pkg::ACT_STATUS, '0, '0, '0, 16'd0,
                 (m_outstanding < srlc_pkg::NR_BUFS) && m_link, 1'b1);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    // with the input still offered, so the caller drops valid when it stops sending.
    task automatic send_event(input srlc_pkg::in_item_t ev);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_event(ev);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        in_valid <= 1'b0;
        wait (expected_cmds.size() == 0);
        repeat (60) @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == srlc_pkg::CFG_DATA_TIMER)
            m_data_tlen = value;
        else
            m_ack_tlen = value;
    endtask

    function automatic srlc_pkg::in_item_t make_event(input logic [2:0] k,
                                                      input logic [9:0] len,
                                                      input logic crc,
                                                      input logic [1:0] ft,
                                                      input logic [SB-1:0] sq,
                                                      input logic [SB-1:0] ak,
                                                      input logic [LB-1:0] ts);
        srlc_pkg::in_item_t ev;
        ev.kind          = k;
        ev.rx_length     = len;
        ev.rx_crc_ok     = crc;
        ev.rx_frame_type = ft;
        ev.rx_seq_number = sq;
        ev.rx_ack_number = ak;
        ev.timeout_slot  = ts;
        return ev;
    endfunction

    // Mostly well-formed traffic: good frames near the window edges, sends and acks.
    function automatic srlc_pkg::in_item_t random_event();
        srlc_pkg::in_item_t ev;
        int                 pick;
        ev   = srlc_pkg::in_item_t'(IN_BITS'($urandom));
        pick = int'($urandom_range(99));
        if (pick < 95)
        begin
            ev.kind = 3'($urandom_range(4));
            if (pick < 70)
            begin
                ev.rx_length     = ($urandom_range(9) == 0) ? srlc_pkg::SHORT_CTRL_LEN
                                                            : 10'($urandom_range(1023, 7));
                ev.rx_crc_ok     = ($urandom_range(9) != 0);
                ev.rx_frame_type = 2'($urandom_range(2));
                ev.rx_seq_number = SB'(m_expected + $urandom_range(3));
                ev.rx_ack_number = SB'(m_oldest + $urandom_range(5) - 1);
            end
        end
        return ev;
    endfunction

    // Output side: stalls and one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        srlc_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cmds.size() == 0)
            begin
                mismatches++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("Unexpected transfer: expected none, got %p", out_data);
                end
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (reports < MAX_REPORTS)
                    begin
                        reports++;
                        $display("Mismatch: expected %p, got %p", want, out_data);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
        end
    end

    srlc_pkg::in_item_t  directed_events[$];
    srlc_pkg::out_item_t first_status;

    initial
    begin
        int i;
        int p;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b1;
        cfg_write_en = 1'b0;
        cfg_index    = srlc_pkg::CFG_DATA_TIMER;
        cfg_data     = '0;
        mismatches   = 0;
        reports      = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_off     = 1'b0;
        timed_out    = 1'b0;
        quiet_cycles = 0;
        rst_n        = 1'b0;

        m_data_tlen   = srlc_pkg::DATA_TIMER_RESET;
        m_ack_tlen    = srlc_pkg::ACK_TIMER_RESET;
        m_next_send   = '0;
        m_oldest      = '0;
        m_expected    = '0;
        m_win_end     = SB'(srlc_pkg::NR_BUFS);
        m_outstanding = 0;
        m_arrived     = '0;
        m_nak_ok      = 1'b1;
        m_link        = 1'b0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table; the first row's status is known outright after reset.
        directed_events = '{
            make_event(srlc_pkg::KIND_LINK, 10'd0, 1'b0, 2'd0, 5'd0, 5'd0, 4'd0),
            make_event(srlc_pkg::KIND_HOST, 10'd0, 1'b0, 2'd0, 5'd0, 5'd0, 4'd0),
            make_event(srlc_pkg::KIND_HOST, 10'd1023, 1'b1, 2'd3, 5'd31, 5'd31, 4'd15),
            make_event(srlc_pkg::KIND_FRAME, 10'd0, 1'b1, srlc_pkg::FTYPE_DATA,
                       5'd0, 5'd31, 4'd0),
            make_event(srlc_pkg::KIND_FRAME, 10'd6, 1'b1, srlc_pkg::FTYPE_DATA,
                       5'd0, 5'd31, 4'd0),
            make_event(srlc_pkg::KIND_FRAME, 10'd7, 1'b0, srlc_pkg::FTYPE_DATA,
                       5'd0, 5'd31, 4'd0),
            make_event(srlc_pkg::KIND_FRAME, 10'd2, 1'b0, srlc_pkg::FTYPE_DATA,
                       5'd1, 5'd31, 4'd0),
            make_event(srlc_pkg::KIND_FRAME, 10'd1023, 1'b1, srlc_pkg::FTYPE_DATA,
                       5'd0, 5'd31, 4'd0),
            make_event(srlc_pkg::KIND_FRAME, 10'd100, 1'b1, srlc_pkg::FTYPE_DATA,
                       5'd2, 5'd31, 4'd0),
            make_event(srlc_pkg::KIND_FRAME, 10'd100, 1'b1, srlc_pkg::FTYPE_DATA,
                       5'd1, 5'd31, 4'd0),
            make_event(srlc_pkg::KIND_FRAME, 10'd9, 1'b1, srlc_pkg::FTYPE_NAK,
                       5'd0, 5'd31, 4'd0),
            make_event(srlc_pkg::KIND_FRAME, 10'd9, 1'b1, srlc_pkg::FTYPE_ACK,
                       5'd0, 5'd0, 4'd0),
            make_event(srlc_pkg::KIND_FRAME, 10'd9, 1'b1, 2'd3, 5'd31, 5'd1, 4'd0),
            make_event(srlc_pkg::KIND_DATA_TO, 10'd0, 1'b0, 2'd0, 5'd0, 5'd0, 4'd15),
            make_event(srlc_pkg::KIND_DATA_TO, 10'd0, 1'b0, 2'd0, 5'd0, 5'd0, 4'd0),
            make_event(srlc_pkg::KIND_ACK_TO, 10'd0, 1'b0, 2'd0, 5'd0, 5'd0, 4'd0),
            make_event(3'd5, 10'd0, 1'b0, 2'd0, 5'd0, 5'd0, 4'd0),
            make_event(3'd7, 10'd1023, 1'b1, 2'd3, 5'd31, 5'd31, 4'd15)
        };
        stall_pct = 0;
        for (i = 0; i < directed_events.size(); i++)
        begin
            send_event(directed_events[i]);
            if (i == 0)
            begin
                first_status = expected_cmds[expected_cmds.size() - 1];
                if (first_status.network_enable !== 1'b1 || first_status.last !== 1'b1)
                begin
                    mismatches++;
                    if (reports < MAX_REPORTS)
                    begin
                        reports++;
                        $display("Mismatch: expected enabled last status, got %p",
                                 first_status);
                    end
                end
            end
        end
        // Fill the window past its limit so a full-window host packet is seen.
        for (i = 0; i < 18; i++)
            send_event(make_event(srlc_pkg::KIND_HOST, 10'd0, 1'b0, 2'd0, 5'd0, 5'd0,
                                  4'd0));

        write_reg(srlc_pkg::CFG_DATA_TIMER, 16'hFFFF);
        write_reg(srlc_pkg::CFG_ACK_TIMER, 16'h0000);

        for (p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 57;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 57;
                end
                3:
                begin
                    idle_pct  = 35;
                    stall_pct = 35;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            if (p == 4)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (i = 0; i < 78; i++)
                send_event(random_event());
            if (p == 1)
            begin
                write_reg(srlc_pkg::CFG_DATA_TIMER, 16'h0000);
                write_reg(srlc_pkg::CFG_ACK_TIMER, 16'hFFFF);
            end
            if (p == 3)
            begin
                write_reg(srlc_pkg::CFG_DATA_TIMER, 16'($urandom_range(65535)));
                write_reg(srlc_pkg::CFG_ACK_TIMER, 16'($urandom_range(65535)));
            end
        end

        in_valid <= 1'b0;
        wait (expected_cmds.size() == 0);
        repeat (100) @(negedge clk);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
